[hw/rtl/assert_macros.svh]
// Assertion helpers, included by the byte controller top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge, suspended while reset is held.
`define ASSERT_CLKRST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_CLKRST(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

[hw/rtl/i2cmbc_pkg.sv]
`timescale 1ns / 1ps
package i2cmbc_pkg;

    localparam int UNIT_W = 16;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

    localparam logic [2:0] OP_IDLE    = 3'd0;
    localparam logic [2:0] OP_RESET   = 3'd1;
    localparam logic [2:0] OP_START   = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_WRITE   = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;

    localparam logic [3:0] BITS_PER_BYTE    = 4'd8;
    localparam logic [3:0] RESET_LAST_PHASE = 4'd13;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       send_nack;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] read_data;
    } out_word_t;

    // Sequencer state kept between words (the tick counter lives in the timer).
    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] phase;
        logic [3:0] bits;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       ack;
        logic       nack;
        logic [7:0] rd_byte;
    } ctl_state_t;

    // idle, both lines released high, SDA not driven
    localparam ctl_state_t CTL_RESET = '{
        cmd:     OP_IDLE,
        phase:   4'd0,
        bits:    4'd0,
        shift:   8'd0,
        scl:     1'b1,
        sda:     1'b1,
        sda_en:  1'b0,
        ack:     1'b0,
        nack:    1'b0,
        rd_byte: 8'd0
    };

    typedef struct packed {
        logic clr;
        logic inc;
    } timer_ctl_t;

endpackage

[hw/rtl/i2cmbc_timer.sv]
`timescale 1ns / 1ps
module i2cmbc_timer #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [i2cmbc_pkg::UNIT_W-1:0] unit_ticks,
    input  i2cmbc_pkg::timer_ctl_t        ctl,
    output logic                          unit_end
);
    import i2cmbc_pkg::*;

    localparam int CMP_W = ((TICK_WIDTH > UNIT_W) ? TICK_WIDTH : UNIT_W) + 1;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << TICK_WIDTH;

    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [CMP_W-1:0]      unit_eff, cnt_plus;

    // zero means one tick; longer than the counter saturates
    always_comb begin
        unit_eff = CMP_W'(unit_ticks);
        if (unit_ticks == '0) begin
            unit_eff = CMP_W'(1);
        end else if (unit_eff > LIMIT) begin
            unit_eff = LIMIT;
        end
        cnt_plus = CMP_W'(tick_reg) + CMP_W'(1);
        unit_end = (cnt_plus >= unit_eff);
    end

    always_comb begin
        tick_next = tick_reg;
        if (ctl.clr) begin
            tick_next = '0;
        end else if (ctl.inc) begin
            tick_next = cnt_plus[TICK_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
        end else if (step) begin
            tick_reg <= tick_next;
        end
    end

endmodule

[hw/rtl/i2cmbc_step.sv]
`timescale 1ns / 1ps
module i2cmbc_step (
    input  i2cmbc_pkg::ctl_state_t st,
    input  i2cmbc_pkg::in_word_t   in_word,
    input  logic                   unit_end,
    output i2cmbc_pkg::ctl_state_t st_next,
    output i2cmbc_pkg::timer_ctl_t tmr,
    output i2cmbc_pkg::out_word_t  res
);
    import i2cmbc_pkg::*;

    // pin actions on entering the current phase
    function automatic ctl_state_t enter_phase(ctl_state_t s, logic sda_in);
        ctl_state_t r;
        r = s;
        case (s.cmd)
            OP_RESET: begin
                case (s.phase)
                    4'd0: begin r.sda_en = 1'b1; r.sda = 1'b1; r.scl = 1'b1; end
                    4'd2: r.scl = 1'b1;
                    4'd4: r.sda = 1'b1;
                    default: ;
                endcase
            end
            OP_START: begin
                case (s.phase)
                    4'd0: begin r.sda_en = 1'b1; r.sda = 1'b1; r.scl = 1'b1; end
                    4'd1: r.scl = 1'b1;
                    4'd2: r.sda = 1'b0;
                    4'd3: r.scl = 1'b0;
                    default: ;
                endcase
            end
            OP_RESTART: begin
                // SCL goes low before SDA is released
                case (s.phase)
                    4'd0: r.scl = 1'b0;
                    4'd1: begin r.sda_en = 1'b1; r.sda = 1'b1; end
                    4'd2: r.scl = 1'b1;
                    4'd3: r.sda = 1'b0;
                    default: ;
                endcase
            end
            OP_STOP: begin
                case (s.phase)
                    4'd0: begin r.sda_en = 1'b1; r.sda = 1'b0; end
                    4'd1: r.scl = 1'b1;
                    4'd2: r.sda = 1'b1;
                    default: ;
                endcase
            end
            OP_WRITE: begin
                case (s.phase)
                    4'd0: begin r.scl = 1'b0; r.sda_en = 1'b1; r.sda = s.shift[7]; end
                    4'd1: r.scl = 1'b1;
                    4'd3: r.scl = 1'b0;
                    4'd4: r.sda_en = 1'b0;
                    4'd5: r.scl = 1'b1;
                    4'd6: begin r.ack = sda_in; r.scl = 1'b0; end
                    default: ;
                endcase
            end
            OP_READ: begin
                case (s.phase)
                    4'd0: begin r.sda_en = 1'b0; r.scl = 1'b0; end
                    4'd1: r.scl = 1'b1;
                    4'd2: r.shift = {s.shift[6:0], sda_in};
                    4'd3: r.scl = 1'b0;
                    4'd5: begin r.sda_en = 1'b1; r.sda = 1'b1; end
                    4'd6: r.sda = s.nack;
                    4'd7: r.scl = 1'b1;
                    4'd8: r.scl = 1'b0;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    ctl_state_t adv;
    logic       fin;
    logic       busy, done;
    logic [3:0] bits_inc;

    assign bits_inc = st.bits + 4'd1;

    // next phase, or end of the sequence
    always_comb begin
        adv = st;
        fin = 1'b0;
        adv.phase = st.phase + 4'd1;
        case (st.cmd)
            OP_WRITE: begin
                if (st.phase == 4'd3) begin
                    adv.shift = {st.shift[6:0], 1'b0};
                    adv.bits  = bits_inc;
                    adv.phase = (bits_inc < BITS_PER_BYTE) ? 4'd0 : 4'd4;
                end else if (st.phase >= 4'd6) begin
                    fin = 1'b1;
                end
            end
            OP_READ: begin
                if (st.phase == 4'd4) begin
                    adv.bits  = bits_inc;
                    adv.phase = (bits_inc < BITS_PER_BYTE) ? 4'd1 : 4'd5;
                end else if (st.phase >= 4'd8) begin
                    fin = 1'b1;
                end
            end
            OP_RESET:              fin = (st.phase >= RESET_LAST_PHASE);
            OP_START, OP_RESTART:  fin = (st.phase >= 4'd3);
            default:               fin = (st.phase >= 4'd2);
        endcase
    end

    always_comb begin
        st_next = st;
        tmr     = '0;
        busy    = 1'b0;
        done    = 1'b0;
        if (st.cmd == OP_IDLE) begin
            if (in_word.operation inside {[OP_RESET:OP_READ]}) begin
                st_next.cmd   = in_word.operation;
                st_next.phase = '0;
                st_next.bits  = '0;
                if (in_word.operation == OP_WRITE) begin
                    st_next.shift = in_word.write_data;
                end
                if (in_word.operation == OP_READ) begin
                    st_next.shift = '0;
                    st_next.nack  = in_word.send_nack;
                end
                st_next = enter_phase(st_next, in_word.sda_in);
                tmr.clr = 1'b1;
                busy    = 1'b1;
            end
        end else begin
            busy = 1'b1;
            if (unit_end) begin
                tmr.clr = 1'b1;
                if (fin) begin
                    st_next = st;
                    if (st.cmd == OP_RESTART) begin
                        st_next.scl = 1'b0;
                    end
                    if (st.cmd == OP_READ) begin
                        st_next.rd_byte = st.shift;
                    end
                    st_next.cmd   = OP_IDLE;
                    st_next.phase = '0;
                    done          = 1'b1;
                end else begin
                    st_next = enter_phase(adv, in_word.sda_in);
                end
            end else begin
                tmr.inc = 1'b1;
            end
        end
    end

    always_comb begin
        res.scl_level = st_next.scl;
        res.sda_drive = st_next.sda_en;
        res.sda_level = st_next.sda;
        res.busy_res  = busy;
        res.done_res  = done;
        res.ack_error = st_next.ack;
        res.read_data = st_next.rd_byte;
    end

endmodule

[hw/rtl/i2c_master_byte_controller_unit.sv]
// I2C master byte controller.
// Each input word on s_ (s_valid/s_ready, s_data) is one bus tick and may
// carry a command: reset, start, restart, stop, write byte or read byte.
// A command is taken only when no sequence runs; otherwise it is a plain tick.
// Every input word yields exactly one result word on m_ (m_valid/m_ready,
// m_data) carrying the SCL/SDA pin levels, busy/done, ack_error, read_data.
// The result is registered and shows the cycle after
// the input word is taken.
// Throughput: one word per cycle; a new word is taken while the result
// register is empty or being drained in that same cycle.
// Bus timing is counted in words: each phase lasts unit_ticks words, set through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, the block does not enforce it.
// Reset (aresetn low, synchronous): sequencer idle, SCL and SDA released
// high, SDA not driven, unit_ticks back to 100.
// A stalled receiver (m_ready low) holds the result word and drops s_ready
// once the register is full, so no tick is lost and the bus timing freezes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2c_master_byte_controller_unit #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [i2cmbc_pkg::UNIT_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  i2cmbc_pkg::in_word_t          s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output i2cmbc_pkg::out_word_t         m_data
);
    import i2cmbc_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    ctl_state_t        state_reg, state_next;
    timer_ctl_t        tmr;
    out_word_t         res;
    out_word_t         m_data_reg;
    logic              m_valid_reg;
    logic              unit_end;
    logic              accept;

    // output register frees up in the same cycle it drains
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= UNIT_RESET;
        end else if (cfg_we) begin
            unit_reg <= cfg_wdata;
        end
    end

    i2cmbc_timer #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .unit_ticks (unit_reg),
        .ctl        (tmr),
        .unit_end   (unit_end)
    );

    i2cmbc_step u_step (
        .st       (state_reg),
        .in_word  (s_data),
        .unit_end (unit_end),
        .st_next  (state_next),
        .tmr      (tmr),
        .res      (res)
    );

    // sequencer state advances once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

    `ASSERT_CLKRST(a_done_goes_idle, aclk, aresetn, accept && res.done_res |=> state_reg.cmd == OP_IDLE, "done without return to idle")
    `ASSERT_CLKRST(a_busy_when_active, aclk, aresetn, accept && state_reg.cmd != OP_IDLE |-> res.busy_res, "active sequence not reported busy")
    `ASSERT_NEVER(a_phase_range, aclk, aresetn, state_reg.phase > RESET_LAST_PHASE, "phase index out of range")
    `ASSERT_NEVER(a_bit_range, aclk, aresetn, state_reg.bits > BITS_PER_BYTE, "bit count past one byte")

endmodule
